FILE: src/pgpl_pkg.sv
package pgpl_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 24;
	localparam int WORK_BITS     = 30;
	localparam int IN_W          = IN_FRAC_BITS + 1;
	localparam int OUT_W         = OUT_FRAC_BITS + 1;
	localparam int WB            = WORK_BITS + 6;
	localparam int CW            = WORK_BITS + 1;

	localparam logic [WB-1:0] W_ONE  = WB'(1) << WORK_BITS;
	localparam logic [WB-1:0] W_HALF = WB'(1) << (WORK_BITS - 1);

	localparam logic [3:0] LAST_COMBO = 4'd8;

	localparam logic [1:0] G_PP = 2'd0;
	localparam logic [1:0] G_PQ = 2'd1;
	localparam logic [1:0] G_QQ = 2'd2;

	localparam logic [3:0] C_PPQQ = 4'd0;
	localparam logic [3:0] C_QQPP = 4'd1;
	localparam logic [3:0] C_PPPQ = 4'd2;
	localparam logic [3:0] C_PQPP = 4'd3;
	localparam logic [3:0] C_PQQQ = 4'd4;
	localparam logic [3:0] C_QQPQ = 4'd5;
	localparam logic [3:0] C_PPPP = 4'd6;
	localparam logic [3:0] C_PQPQ = 4'd7;
	localparam logic [3:0] C_QQQQ = 4'd8;

	typedef logic [WB-1:0] work_t;
	typedef work_t [2:0] vec3_t;
	typedef vec3_t [2:0] mat3_t;
	typedef mat3_t [2:0] cube_t;
	typedef work_t [8:0] res_t;

	typedef struct packed {
		vec3_t qg;
		mat3_t t;
		mat3_t qgt;
		mat3_t inner;
		mat3_t pairq;
	} tab_t;

	function automatic logic [CW-1:0] clamp_one(work_t v);
		logic [CW-1:0] r;
		r = (v > W_ONE) ? W_ONE[CW-1:0] : v[CW-1:0];
		return r;
	endfunction

	function automatic work_t fx_mul(work_t a, work_t b);
		logic [2*CW-1:0] pr;
		pr = clamp_one(a) * clamp_one(b);
		return WB'(pr[2*CW-1:WORK_BITS]);
	endfunction

	function automatic work_t in_to_work(logic [IN_W-1:0] raw);
		logic [IN_W-1:0] s;
		s = (raw > (IN_W'(1) << IN_FRAC_BITS)) ? (IN_W'(1) << IN_FRAC_BITS) : raw;
		return WB'(s) << (WORK_BITS - IN_FRAC_BITS);
	endfunction

	function automatic logic [OUT_W-1:0] work_to_out(work_t v);
		work_t c;
		c = WB'(clamp_one(v));
		return OUT_W'(c >> (WORK_BITS - OUT_FRAC_BITS));
	endfunction

	function automatic logic [2:0] tx_x2(logic [1:0] allele, logic [1:0] g);
		logic [2:0] r;
		case (g)
			G_PP:    r = (allele == 2'd0) ? 3'd2 : 3'd0;
			G_PQ:    r = 3'd1;
			G_QQ:    r = (allele == 2'd0) ? 3'd0 : 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] t2_x4(logic [1:0] c, logic [1:0] a, logic [1:0] b);
		logic [5:0] r;
		case (c)
			G_PP:    r = tx_x2(2'd0, a) * tx_x2(2'd0, b);
			G_PQ:    r = tx_x2(2'd0, a) * tx_x2(2'd1, b) + tx_x2(2'd1, a) * tx_x2(2'd0, b);
			G_QQ:    r = tx_x2(2'd1, a) * tx_x2(2'd1, b);
			default: r = 6'd0;
		endcase
		return r[2:0];
	endfunction

	function automatic work_t t2_mul(work_t x, logic [2:0] k);
		work_t c;
		work_t r;
		c = WB'(clamp_one(x));
		case (k)
			3'd4:    r = c;
			3'd2:    r = c >> 1;
			3'd1:    r = c >> 2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] combo_g1(logic [3:0] k);
		logic [1:0] g;
		case (k)
			C_PPQQ, C_PPPQ, C_PPPP: g = G_PP;
			C_PQPP, C_PQQQ, C_PQPQ: g = G_PQ;
			C_QQPP, C_QQPQ, C_QQQQ: g = G_QQ;
			default:                g = G_PP;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] combo_g2(logic [3:0] k);
		logic [1:0] g;
		case (k)
			C_QQPP, C_PQPP, C_PPPP: g = G_PP;
			C_PPPQ, C_QQPQ, C_PQPQ: g = G_PQ;
			C_PPQQ, C_PQQQ, C_QQQQ: g = G_QQ;
			default:                g = G_PP;
		endcase
		return g;
	endfunction

endpackage

FILE: src/pgpl_front.sv
module pgpl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pgpl_pkg::IN_W-1:0]     allele_freq,
	input  logic [pgpl_pkg::IN_W-1:0]     fst,
	input  logic                          take,
	output logic                          tab_valid,
	output pgpl_pkg::tab_t                tab
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	pgpl_pkg::work_t p_s1, q_s1, f_s1, omf_s1;
	pgpl_pkg::work_t p_s2, q_s2, f_s2, p0_s2, q0_s2;
	pgpl_pkg::work_t p_s3, q_s3;
	pgpl_pkg::mat3_t t_s3, t_s4, tn;
	pgpl_pkg::vec3_t qg_s4;
	pgpl_pkg::cube_t innm_s4;
	pgpl_pkg::work_t p_in, f_in, p1, q1;
	pgpl_pkg::tab_t  tab_s5, tab_n;

	assign en5 = !v_s5 || take;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	assign p_in = pgpl_pkg::in_to_work(allele_freq);
	assign f_in = pgpl_pkg::in_to_work(fst);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		p1 = p0_s2 + f_s2;
		q1 = q0_s2 + f_s2;
		tn[0][0] = p1;
		tn[1][0] = q0_s2;
		tn[2][0] = '0;
		tn[0][1] = p1 >> 1;
		tn[1][1] = pgpl_pkg::W_HALF;
		tn[2][1] = q0_s2 >> 1;
		tn[0][2] = '0;
		tn[1][2] = p0_s2;
		tn[2][2] = q1;
	end

	always_comb begin
		tab_n.qg = qg_s4;
		tab_n.t  = t_s4;
		for (int x = 0; x < 3; x++) begin
			for (int a = 0; a < 3; a++) begin
				tab_n.inner[x][a] = innm_s4[x][a][0] + innm_s4[x][a][1] + innm_s4[x][a][2];
				tab_n.qgt[x][a]   = pgpl_pkg::fx_mul(qg_s4[a], t_s4[x][a]);
				tab_n.pairq[x][a] = pgpl_pkg::fx_mul(qg_s4[x], qg_s4[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1   <= p_in;
			q_s1   <= pgpl_pkg::W_ONE - p_in;
			f_s1   <= f_in;
			omf_s1 <= pgpl_pkg::W_ONE - f_in;
		end
		if (en2) begin
			p_s2  <= p_s1;
			q_s2  <= q_s1;
			f_s2  <= f_s1;
			p0_s2 <= pgpl_pkg::fx_mul(omf_s1, p_s1);
			q0_s2 <= pgpl_pkg::fx_mul(omf_s1, q_s1);
		end
		if (en3) begin
			p_s3 <= p_s2;
			q_s3 <= q_s2;
			t_s3 <= tn;
		end
		if (en4) begin
			t_s4     <= t_s3;
			qg_s4[0] <= pgpl_pkg::fx_mul(p_s3, t_s3[0][0]);
			qg_s4[1] <= pgpl_pkg::fx_mul(p_s3, t_s3[1][0]) << 1;
			qg_s4[2] <= pgpl_pkg::fx_mul(q_s3, t_s3[2][2]);
			for (int x = 0; x < 3; x++)
				for (int a = 0; a < 3; a++)
					for (int b = 0; b < 3; b++)
						innm_s4[x][a][b] <= pgpl_pkg::fx_mul(t_s3[b][a], t_s3[x][b]);
		end
		if (en5) tab_s5 <= tab_n;
	end

	assign tab_valid = v_s5;
	assign tab       = tab_s5;

endmodule

FILE: src/pgpl_pair.sv
module pgpl_pair (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [3:0]          k_in,
	input  pgpl_pkg::tab_t      tab,
	output logic                vout,
	output logic [3:0]          k_out,
	output pgpl_pkg::res_t      res
);

	logic [1:0] g1, g2;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [3:0] k_s1, k_s2, k_s3, k_s4;

	pgpl_pkg::work_t v0_s1, v1_s1, v2_s1, qg1_s1, gp_s1;
	pgpl_pkg::vec3_t qgt1_s1, tg2_s1, inn_s1, tc1_s1;
	pgpl_pkg::mat3_t pairq_s1, s1_s1, s2_s1, fst_s1;
	pgpl_pkg::mat3_t s1n, s2n, fstn;

	pgpl_pkg::work_t v0_s2, v1_s2, v2_s2, v5_s2, fs_s2, qg1_s2;
	pgpl_pkg::vec3_t hsm_s2, avm_s2, ggm_s2;
	pgpl_pkg::mat3_t fcm_s2, s2_s2;
	pgpl_pkg::work_t fsn;

	pgpl_pkg::work_t v0_s3, v1_s3, v2_s3, v5_s3, fs_s3, qg1_s3, hs_s3, av_s3, ggp_s3;
	pgpl_pkg::mat3_t fcm2_s3;

	pgpl_pkg::res_t  res_s4;
	pgpl_pkg::work_t fcn;

	assign g1 = pgpl_pkg::combo_g1(k_in);
	assign g2 = pgpl_pkg::combo_g2(k_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				s1n[a][b] = '0;
				s2n[a][b] = '0;
				for (int c = 0; c < 3; c++) begin
					s1n[a][b] = s1n[a][b] + pgpl_pkg::t2_mul(tab.t[g1][c],
						pgpl_pkg::t2_x4(2'(c), 2'(a), 2'(b)));
					s2n[a][b] = s2n[a][b] + pgpl_pkg::t2_mul(tab.t[g2][c],
						pgpl_pkg::t2_x4(2'(c), 2'(a), 2'(b)));
				end
				fstn[a][b] = pgpl_pkg::t2_mul(
					pgpl_pkg::t2_mul(tab.pairq[a][b], pgpl_pkg::t2_x4(g1, 2'(a), 2'(b))),
					pgpl_pkg::t2_x4(g2, 2'(a), 2'(b)));
			end
		end
	end

	always_comb begin
		fsn = '0;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				fsn = fsn + fst_s1[a][b];
	end

	always_comb begin
		fcn = '0;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				fcn = fcn + fcm2_s3[a][b];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1   <= k_in;
			v0_s1  <= tab.pairq[g1][g2];
			v1_s1  <= (g1 == g2) ? tab.qg[g1] : '0;
			v2_s1  <= (tab.qgt[g2][g1] >> 1) + (tab.qgt[g1][g2] >> 1);
			qg1_s1 <= tab.qg[g1];
			gp_s1  <= tab.inner[g2][g1];
			for (int a = 0; a < 3; a++) begin
				qgt1_s1[a] <= tab.qgt[g1][a];
				tg2_s1[a]  <= tab.t[g2][a];
				inn_s1[a]  <= tab.inner[g2][a];
				tc1_s1[a]  <= tab.t[a][g1];
			end
			pairq_s1 <= tab.pairq;
			s1_s1    <= s1n;
			s2_s1    <= s2n;
			fst_s1   <= fstn;

			k_s2   <= k_s1;
			v0_s2  <= v0_s1;
			v1_s2  <= v1_s1;
			v2_s2  <= v2_s1;
			qg1_s2 <= qg1_s1;
			v5_s2  <= pgpl_pkg::fx_mul(qg1_s1, gp_s1);
			fs_s2  <= fsn;
			s2_s2  <= s2_s1;
			for (int a = 0; a < 3; a++) begin
				hsm_s2[a] <= pgpl_pkg::fx_mul(qgt1_s1[a], tg2_s1[a]);
				avm_s2[a] <= pgpl_pkg::fx_mul(qgt1_s1[a], inn_s1[a]);
				ggm_s2[a] <= pgpl_pkg::fx_mul(tc1_s1[a], inn_s1[a]);
				for (int b = 0; b < 3; b++)
					fcm_s2[a][b] <= pgpl_pkg::fx_mul(pairq_s1[a][b], s1_s1[a][b]);
			end

			k_s3   <= k_s2;
			v0_s3  <= v0_s2;
			v1_s3  <= v1_s2;
			v2_s3  <= v2_s2;
			v5_s3  <= v5_s2;
			fs_s3  <= fs_s2;
			qg1_s3 <= qg1_s2;
			hs_s3  <= hsm_s2[0] + hsm_s2[1] + hsm_s2[2];
			av_s3  <= avm_s2[0] + avm_s2[1] + avm_s2[2];
			ggp_s3 <= ggm_s2[0] + ggm_s2[1] + ggm_s2[2];
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++)
					fcm2_s3[a][b] <= pgpl_pkg::fx_mul(fcm_s2[a][b], s2_s2[a][b]);

			k_s4      <= k_s3;
			res_s4[0] <= v0_s3;
			res_s4[1] <= v1_s3;
			res_s4[2] <= v2_s3;
			res_s4[3] <= hs_s3;
			res_s4[4] <= av_s3;
			res_s4[5] <= v5_s3;
			res_s4[6] <= fs_s3;
			res_s4[7] <= fcn;
			res_s4[8] <= pgpl_pkg::fx_mul(qg1_s3, ggp_s3);
		end
	end

	assign vout  = v_s4;
	assign k_out = k_s4;
	assign res   = res_s4;

endmodule

FILE: src/pedigree_genotype_pair_likelihood.sv
// Genotype-pair likelihoods of one biallelic marker under nine relationships.
// Input channel: in_valid/in_stall carry one request, the allele frequency of P
// (unsigned Q1.16). The user must write the structure coefficient F through
// cfg_wr_en/cfg_wr_data only while the block is idle (not enforced); it resets to zero.
// Output channel: out_valid/out_stall carry nine results per request, in pair
// code order 0..8, last_flag set on the ninth. Each probability is Q1.24.
// An accepted request passes the table stages, the table register, the pair
// stages and the output register; results then follow one per cycle while
// the output is not stalled, so one request is taken per nine results; a
// five-stage table pipeline builds the next marker while the four-stage pair
// pipeline drains the current one.
// Reset clears every valid bit, the pair sequencer and the coefficient.
// When the receiver stalls, the pair pipeline and the sequencer freeze; the
// table pipeline keeps filling and then raises in_stall. Nothing is dropped.
module pedigree_genotype_pair_likelihood (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pgpl_pkg::IN_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pgpl_pkg::IN_W-1:0]         allele_freq,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        combo_index,
	output logic                              last_flag,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_unrelated,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_duplicate,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_parent_offspring,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_half_sibling,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_avuncular,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_grandparent,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_full_sibling,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_first_cousin,
	output logic [pgpl_pkg::OUT_W-1:0]        prob_great_grandparent
);

	logic [pgpl_pkg::IN_W-1:0] fst_q;
	logic adv, take, ld_ok, tab_valid, busy_q, pv;
	logic [3:0] cnt_q, pk;
	logic out_valid_q;
	pgpl_pkg::tab_t ftab, tab_q;
	pgpl_pkg::res_t pres;

	assign adv   = !out_valid_q || !out_stall;
	assign ld_ok = !busy_q || (cnt_q == pgpl_pkg::LAST_COMBO);
	assign take  = adv && ld_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= '0;
		end else if (cfg_wr_en) begin
			fst_q <= cfg_wr_data;
		end
	end

	pgpl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.allele_freq (allele_freq),
		.fst         (fst_q),
		.take        (take),
		.tab_valid   (tab_valid),
		.tab         (ftab)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (adv) begin
			if (busy_q && cnt_q != pgpl_pkg::LAST_COMBO) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				busy_q <= tab_valid;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tab_valid) tab_q <= ftab;
	end

	pgpl_pair u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (busy_q),
		.k_in   (cnt_q),
		.tab    (tab_q),
		.vout   (pv),
		.k_out  (pk),
		.res    (pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			combo_index            <= pk;
			last_flag              <= (pk == pgpl_pkg::LAST_COMBO);
			prob_unrelated         <= pgpl_pkg::work_to_out(pres[0]);
			prob_duplicate         <= pgpl_pkg::work_to_out(pres[1]);
			prob_parent_offspring  <= pgpl_pkg::work_to_out(pres[2]);
			prob_half_sibling      <= pgpl_pkg::work_to_out(pres[3]);
			prob_avuncular         <= pgpl_pkg::work_to_out(pres[4]);
			prob_grandparent       <= pgpl_pkg::work_to_out(pres[5]);
			prob_full_sibling      <= pgpl_pkg::work_to_out(pres[6]);
			prob_first_cousin      <= pgpl_pkg::work_to_out(pres[7]);
			prob_great_grandparent <= pgpl_pkg::work_to_out(pres[8]);
		end
	end

	assign out_valid = out_valid_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pgpl_pkg::LAST_COMBO)
		else $error("pair counter out of range");

	a_no_load_midway: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != pgpl_pkg::LAST_COMBO |-> !take)
		else $error("table load while pairs are pending");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && combo_index != pgpl_pkg::LAST_COMBO |=> out_valid)
		else $error("gap inside a marker's results");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && combo_index != pgpl_pkg::LAST_COMBO
		|=> combo_index == 4'($past(combo_index) + 4'd1))
		else $error("pair codes out of order");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_flag |=> !out_valid || combo_index == 4'd0)
		else $error("marker does not start at pair code zero");

endmodule
